// ===== src/acs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, codes and reset values of the ADC channel statistics block.
// ----------------------------------------------------------------------------
package acs_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 8;

    // Field widths
    localparam int OP_W       = 2;
    localparam int CH_W       = 8;
    localparam int RAW_W      = 16;
    localparam int TEMP_W     = 16;
    localparam int STATUS_W   = 8;
    localparam int IDX_W      = 4;
    localparam int VALUE_W    = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int MASK_W     = 8;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = 64;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_LIMIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MASK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MASK  = 8'd3;

    // Configuration reset values
    localparam logic [RAW_W-1:0]  RST_OVER_LIMIT  = 16'hFFFF;
    localparam logic [RAW_W-1:0]  RST_UNDER_LIMIT = 16'h0000;
    localparam logic [MASK_W-1:0] RST_FAULT_MASK  = 8'h01;
    localparam logic [MASK_W-1:0] RST_RANGE_MASK  = 8'h02;

    // Statistic indexes
    localparam logic [IDX_W-1:0] STAT_COUNT    = 4'd0;
    localparam logic [IDX_W-1:0] STAT_OVER     = 4'd1;
    localparam logic [IDX_W-1:0] STAT_UNDER    = 4'd2;
    localparam logic [IDX_W-1:0] STAT_FAULT    = 4'd3;
    localparam logic [IDX_W-1:0] STAT_RANGE    = 4'd4;
    localparam logic [IDX_W-1:0] STAT_MEAN     = 4'd5;
    localparam logic [IDX_W-1:0] STAT_RMS      = 4'd6;
    localparam logic [IDX_W-1:0] STAT_MIN      = 4'd7;
    localparam logic [IDX_W-1:0] STAT_MAX      = 4'd8;
    localparam logic [IDX_W-1:0] STAT_STDDEV   = 4'd9;
    localparam logic [IDX_W-1:0] STAT_TEMP_AVG = 4'd10;
    localparam logic [IDX_W-1:0] STAT_TEMP_MIN = 4'd11;
    localparam logic [IDX_W-1:0] STAT_TEMP_MAX = 4'd12;
    localparam logic [IDX_W-1:0] NUM_STATS     = 4'd13;

endpackage

// ===== src/acs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_if
// Valid/ready channels for sample items and statistic items.
// ----------------------------------------------------------------------------
interface acs_sample_if;
    logic                                valid;
    logic                                ready;
    logic [acs_pkg::OP_W-1:0]            opcode;
    logic [acs_pkg::CH_W-1:0]            channel;
    logic [acs_pkg::RAW_W-1:0]           adc_code;
    logic signed [acs_pkg::TEMP_W-1:0]   temp_tenths;
    logic [acs_pkg::STATUS_W-1:0]        status_bits;

    modport source (output valid, opcode, channel, adc_code, temp_tenths,
                    status_bits, input ready);
    modport sink (input valid, opcode, channel, adc_code, temp_tenths,
                  status_bits, output ready);
endinterface

interface acs_stat_if;
    logic                                valid;
    logic                                ready;
    logic [acs_pkg::CH_W-1:0]            stat_channel;
    logic [acs_pkg::IDX_W-1:0]           stat_index;
    logic signed [acs_pkg::VALUE_W-1:0]  stat_value;
    logic                                last;

    modport source (output valid, stat_channel, stat_index, stat_value, last,
                    input ready);
    modport sink (input valid, stat_channel, stat_index, stat_value, last,
                  output ready);
endinterface

// ===== src/adc_channel_statistics_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_statistics_top
// Per-channel running statistics of tagged ADC samples.
// ----------------------------------------------------------------------------
// One item is worked on at a time; samples.ready is high only while idle.
// An add steps through the accumulator memory read, the 16x16 square and the
// write-back before the next accept. An add to an out-of-range channel, a
// clear and an unused opcode are done in the accepting state (per-channel
// valid bits drop at once on a clear, no sweep).
// A read of a non-empty channel runs the arithmetic first: a shared restoring
// divider retires one quotient bit a cycle for the mean, the mean square and
// the temperature mean, and a shared square-root unit retires one root bit a
// cycle for RMS and standard deviation. Then the 13 statistic items leave
// through an output register, one per cycle while stats.ready is high.
// Empty and out-of-range channels skip the arithmetic and send zero values.
// ----------------------------------------------------------------------------
module adc_channel_statistics_top #(
    parameter int CHANNELS    = acs_pkg::DEF_CHANNELS,
    parameter int COUNT_WIDTH = acs_pkg::DEF_COUNT_WIDTH,
    parameter int FRAC_BITS   = acs_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    acs_sample_if.sink                        samples,
    acs_stat_if.source                        stats,
    input  logic                              cfg_write,
    input  logic [acs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import acs_pkg::*;

    localparam int CW        = COUNT_WIDTH;
    localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_W     = SQ_W + 2 * FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int MEAN_W    = RAW_W + FRAC_BITS;
    localparam logic [CW-1:0]   COUNT_MAX = {CW{1'b1}};
    localparam logic [CH_W:0]   CH_LIMIT  = (CH_W + 1)'(CHANNELS);

    // FSM codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_M2   = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    // Divider and root jobs
    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_MS   = 2'd1;
    localparam logic [1:0] DIV_TEMP = 2'd2;
    localparam logic       RT_RMS   = 1'b0;
    localparam logic       RT_SD    = 1'b1;

    // One accumulator record per channel
    typedef struct packed {
        logic [CW-1:0]           count;
        logic [CW-1:0]           over_cnt;
        logic [CW-1:0]           under_cnt;
        logic [CW-1:0]           fault_cnt;
        logic [CW-1:0]           range_cnt;
        logic [RAW_W-1:0]        raw_min;
        logic [RAW_W-1:0]        raw_max;
        logic [SUM_W-1:0]        raw_sum;
        logic [SQ_W-1:0]         sq_sum;
        logic signed [SUM_W-1:0] temp_sum;
        logic signed [TEMP_W-1:0] temp_min;
        logic signed [TEMP_W-1:0] temp_max;
    } rec_t;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // Configuration registers
    logic [RAW_W-1:0]  over_limit_reg;
    logic [RAW_W-1:0]  under_limit_reg;
    logic [MASK_W-1:0] fault_mask_reg;
    logic [MASK_W-1:0] range_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_limit_reg  <= RST_OVER_LIMIT;
            under_limit_reg <= RST_UNDER_LIMIT;
            fault_mask_reg  <= RST_FAULT_MASK;
            range_mask_reg  <= RST_RANGE_MASK;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OVER_LIMIT:  over_limit_reg  <= cfg_data;
                CFG_UNDER_LIMIT: under_limit_reg <= cfg_data;
                CFG_FAULT_MASK:  fault_mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_RANGE_MASK:  range_mask_reg  <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and item registers
    logic [2:0]          state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic                rd_valid_reg;
    rec_t                rd_data_reg;
    logic [2*RAW_W-1:0]  square_reg;
    logic                zero_reg;
    logic [IDX_W-1:0]    idx_reg;

    // Arithmetic registers
    logic [DIV_W-1:0]     div_q_reg;
    logic [CW-1:0]        div_rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]           div_sel_reg;
    logic                 tneg_reg;
    logic [VALUE_W-1:0]   mean_reg;
    logic [VALUE_W-1:0]   ms_reg;
    logic [VALUE_W-1:0]   tmean_reg;
    logic [VALUE_W-1:0]   m2_reg;
    logic [VALUE_W-1:0]   rms_reg;
    logic [VALUE_W-1:0]   sd_reg;
    logic [VALUE_W-1:0]   rt_v_reg;
    logic [VALUE_W-1:0]   rt_r_reg;
    logic [VALUE_W-1:0]   rt_bit_reg;
    logic                 rt_sel_reg;

    // Output register
    logic                 out_valid_reg;
    logic [CH_W-1:0]      out_ch_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_last_reg;

    rec_t mem [CHANNELS];

    logic            accept;
    logic            in_range;
    logic [CH_AW-1:0] in_addr;
    logic [CH_AW-1:0] wr_addr;
    rec_t            rec;
    rec_t            upd;
    logic            first;
    logic            saturated;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign in_range      = ({1'b0, samples.channel} < CH_LIMIT);
    assign in_addr       = samples.channel[CH_AW-1:0];
    assign wr_addr       = ch_reg[CH_AW-1:0];

    // Entries never written since reset or clear read as zero
    assign rec       = rd_valid_reg ? rd_data_reg : '0;
    assign first     = (rec.count == '0);
    assign saturated = (rec.count == COUNT_MAX);

    // Accumulator update for an add
    always_comb
    begin
        upd           = rec;
        upd.count     = rec.count + 1'b1;
        upd.raw_sum   = rec.raw_sum + SUM_W'(raw_reg);
        upd.sq_sum    = rec.sq_sum + SQ_W'(square_reg);
        upd.temp_sum  = rec.temp_sum + {{(SUM_W - TEMP_W){temp_reg[TEMP_W-1]}}, temp_reg};
        if (first)
        begin
            upd.raw_min  = raw_reg;
            upd.raw_max  = raw_reg;
            upd.temp_min = temp_reg;
            upd.temp_max = temp_reg;
        end
        else
        begin
            if (raw_reg < rec.raw_min) upd.raw_min = raw_reg;
            if (raw_reg > rec.raw_max) upd.raw_max = raw_reg;
            if ($signed(temp_reg) < $signed(rec.temp_min)) upd.temp_min = temp_reg;
            if ($signed(temp_reg) > $signed(rec.temp_max)) upd.temp_max = temp_reg;
        end
        if (raw_reg > over_limit_reg)         upd.over_cnt  = sat_inc(rec.over_cnt);
        if (raw_reg < under_limit_reg)        upd.under_cnt = sat_inc(rec.under_cnt);
        if ((status_reg & fault_mask_reg) != '0) upd.fault_cnt = sat_inc(rec.fault_cnt);
        if ((status_reg & range_mask_reg) != '0) upd.range_cnt = sat_inc(rec.range_cnt);
    end

    // Divider step: one quotient bit per cycle
    logic [CW:0]       div_trial;
    logic              div_fits;
    logic [CW-1:0]     div_rem_step;
    logic [DIV_W-1:0]  div_q_step;

    assign div_trial    = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign div_fits     = (div_trial >= {1'b0, rec.count});
    assign div_rem_step = div_fits ? CW'(div_trial - {1'b0, rec.count})
                                   : div_trial[CW-1:0];
    assign div_q_step   = {div_q_reg[DIV_W-2:0], div_fits};

    // Square of the mean, full width
    logic [2*MEAN_W-1:0] m2_prod;
    assign m2_prod = mean_reg[MEAN_W-1:0] * mean_reg[MEAN_W-1:0];

    // Square-root step: one root bit per cycle
    logic [VALUE_W-1:0] rt_sum;
    logic               rt_ge;
    logic [VALUE_W-1:0] rt_r_step;
    logic [VALUE_W-1:0] rt_v_step;

    assign rt_sum    = rt_r_reg + rt_bit_reg;
    assign rt_ge     = (rt_v_reg >= rt_sum);
    assign rt_r_step = rt_ge ? ((rt_r_reg >> 1) + rt_bit_reg) : (rt_r_reg >> 1);
    assign rt_v_step = rt_ge ? (rt_v_reg - rt_sum) : rt_v_reg;

    // Temperature magnitude
    logic [SUM_W-1:0] tmag;
    assign tmag = rec.temp_sum[SUM_W-1] ? SUM_W'(-rec.temp_sum) : rec.temp_sum;

    // Memory: one read port, one write port
    logic mem_we;
    assign mem_we = (state_reg == S_WR) && !saturated;

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            rd_data_reg <= mem[in_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= upd;
        end
    end

    // Main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            zero_reg     <= 1'b0;
            idx_reg      <= '0;
            div_cnt_reg  <= '0;
            div_sel_reg  <= DIV_MEAN;
            rt_sel_reg   <= RT_RMS;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= samples.opcode;
                        ch_reg       <= samples.channel;
                        raw_reg      <= samples.adc_code;
                        temp_reg     <= samples.temp_tenths;
                        status_reg   <= samples.status_bits;
                        rd_valid_reg <= in_range && valid_reg[in_addr];
                        case (samples.opcode)
                            OP_ADD:
                                if (in_range) state_reg <= S_SQ;
                            OP_READ:
                            begin
                                idx_reg <= '0;
                                if (in_range)
                                begin
                                    state_reg <= S_LOAD;
                                end
                                else
                                begin
                                    zero_reg  <= 1'b1;
                                    state_reg <= S_EMIT;
                                end
                            end
                            OP_CLEAR:
                                valid_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                S_SQ:
                begin
                    square_reg <= raw_reg * raw_reg;
                    state_reg  <= S_WR;
                end
                S_WR:
                begin
                    if (!saturated) valid_reg[wr_addr] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_LOAD:
                begin
                    if (first)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        zero_reg    <= 1'b0;
                        tneg_reg    <= rec.temp_sum[SUM_W-1];
                        div_q_reg   <= DIV_W'(rec.raw_sum) << FRAC_BITS;
                        div_rem_reg <= '0;
                        div_cnt_reg <= DIV_CNT_W'(DIV_W);
                        div_sel_reg <= DIV_MEAN;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(1))
                    begin
                        div_rem_reg <= '0;
                        case (div_sel_reg)
                            DIV_MEAN:
                            begin
                                mean_reg    <= div_q_step[VALUE_W-1:0];
                                div_q_reg   <= DIV_W'(rec.sq_sum) << (2 * FRAC_BITS);
                                div_cnt_reg <= DIV_CNT_W'(DIV_W);
                                div_sel_reg <= DIV_MS;
                            end
                            DIV_MS:
                            begin
                                ms_reg      <= div_q_step[VALUE_W-1:0];
                                div_q_reg   <= DIV_W'(tmag) << FRAC_BITS;
                                div_cnt_reg <= DIV_CNT_W'(DIV_W);
                                div_sel_reg <= DIV_TEMP;
                            end
                            default:
                            begin
                                tmean_reg <= tneg_reg ? -div_q_step[VALUE_W-1:0]
                                                      : div_q_step[VALUE_W-1:0];
                                div_cnt_reg <= '0;
                                state_reg   <= S_M2;
                            end
                        endcase
                    end
                    else
                    begin
                        div_q_reg   <= div_q_step;
                        div_rem_reg <= div_rem_step;
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                    end
                end
                S_M2:
                begin
                    m2_reg     <= VALUE_W'(m2_prod);
                    rt_v_reg   <= ms_reg;
                    rt_r_reg   <= '0;
                    rt_bit_reg <= VALUE_W'(1) << (VALUE_W - 2);
                    rt_sel_reg <= RT_RMS;
                    state_reg  <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (rt_bit_reg == VALUE_W'(1))
                    begin
                        if (rt_sel_reg == RT_RMS)
                        begin
                            rms_reg <= rt_r_step;
                            if (ms_reg >= m2_reg)
                            begin
                                rt_v_reg   <= ms_reg - m2_reg;
                                rt_r_reg   <= '0;
                                rt_bit_reg <= VALUE_W'(1) << (VALUE_W - 2);
                                rt_sel_reg <= RT_SD;
                            end
                            else
                            begin
                                sd_reg    <= '0;
                                state_reg <= S_EMIT;
                            end
                        end
                        else
                        begin
                            sd_reg    <= rt_r_step;
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        rt_v_reg   <= rt_v_step;
                        rt_r_reg   <= rt_r_step;
                        rt_bit_reg <= rt_bit_reg >> 2;
                    end
                end
                S_EMIT:
                begin
                    if (idx_reg == NUM_STATS)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!out_valid_reg || stats.ready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Statistic selection
    logic [VALUE_W-1:0] stat_sel;

    always_comb
    begin
        stat_sel = '0;
        case (idx_reg)
            STAT_COUNT:    stat_sel = VALUE_W'(rec.count);
            STAT_OVER:     stat_sel = VALUE_W'(rec.over_cnt);
            STAT_UNDER:    stat_sel = VALUE_W'(rec.under_cnt);
            STAT_FAULT:    stat_sel = VALUE_W'(rec.fault_cnt);
            STAT_RANGE:    stat_sel = VALUE_W'(rec.range_cnt);
            STAT_MEAN:     stat_sel = mean_reg;
            STAT_RMS:      stat_sel = rms_reg;
            STAT_MIN:      stat_sel = VALUE_W'(rec.raw_min);
            STAT_MAX:      stat_sel = VALUE_W'(rec.raw_max);
            STAT_STDDEV:   stat_sel = sd_reg;
            STAT_TEMP_AVG: stat_sel = tmean_reg;
            STAT_TEMP_MIN: stat_sel = {{(VALUE_W - TEMP_W){rec.temp_min[TEMP_W-1]}},
                                       rec.temp_min};
            STAT_TEMP_MAX: stat_sel = {{(VALUE_W - TEMP_W){rec.temp_max[TEMP_W-1]}},
                                       rec.temp_max};
            default:       stat_sel = '0;
        endcase
    end

    // Output register; the last item may still wait while the next item enters,
    // so it keeps its own copy of the channel
    logic out_load;
    assign out_load = (state_reg == S_EMIT) && (idx_reg != NUM_STATS) &&
                      (!out_valid_reg || stats.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg    <= ch_reg;
            out_idx_reg   <= idx_reg;
            out_value_reg <= zero_reg ? '0 : stat_sel;
            out_last_reg  <= (idx_reg == STAT_TEMP_MAX);
        end
    end

    assign stats.valid        = out_valid_reg;
    assign stats.stat_channel = out_ch_reg;
    assign stats.stat_index   = out_idx_reg;
    assign stats.stat_value   = out_value_reg;
    assign stats.last         = out_last_reg;

    // op_reg is kept for debug visibility of the item in flight
    logic op_is_read;
    assign op_is_read = (op_reg == OP_READ);

    // Assertions
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        stats.valid && stats.last |-> stats.stat_index == STAT_TEMP_MAX)
        else $error("last flag on a statistic other than the final one");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && samples.opcode == OP_CLEAR |=> valid_reg == '0)
        else $error("clear left a channel valid");

    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg != '0)
        else $error("divider running with a zero step count");

    a_emit_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> op_is_read)
        else $error("statistics emitted for an item that is not a read");

endmodule

// ===== tb/adc_channel_statistics_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_statistics_top_tb
// Self-checking bench for the ADC channel statistics block: adds, reads and
// clears are driven over the sample channel, every statistic item is compared
// against an in-bench predictor of the per-channel accumulators.
// ----------------------------------------------------------------------------
module adc_channel_statistics_top_tb;
    import acs_pkg::*;

    localparam int NCH    = DEF_CHANNELS;
    localparam int FRAC   = DEF_FRAC_BITS;
    localparam int CNT_W  = DEF_COUNT_WIDTH;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    // a full read plus slack; used before a register write and at the end
    localparam int DRAIN_CYCLES = 3 * (64 + 2 * FRAC) + 120;
    // opcode with no function
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [IDX_W-1:0]    idx;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } stat_item_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    acs_sample_if samples ();
    acs_stat_if   stats ();

    adc_channel_statistics_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .stats     (stats),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------- predictor state ----------------
    logic [RAW_W-1:0]  over_limit, under_limit;
    logic [MASK_W-1:0] fault_mask, range_mask;

    longint unsigned n_samples [NCH];
    longint unsigned n_over    [NCH];
    longint unsigned n_under   [NCH];
    longint unsigned n_fault   [NCH];
    longint unsigned n_range   [NCH];
    logic [RAW_W-1:0]          raw_lo  [NCH];
    logic [RAW_W-1:0]          raw_hi  [NCH];
    longint unsigned           raw_acc [NCH];
    longint unsigned           sq_acc  [NCH];
    longint                    temp_acc[NCH];
    logic signed [TEMP_W-1:0]  temp_lo [NCH];
    logic signed [TEMP_W-1:0]  temp_hi [NCH];

    stat_item_t expected_stats[$];

    int  errors;
    int  stall_left;
    bit  idle_sender, idle_receiver;
    longint unsigned cycles;

    // ---------------- clock, reset, watchdog ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned count_step(longint unsigned c);
        longint unsigned cmax;
        cmax = (64'd1 << CNT_W) - 1;
        return (c < cmax) ? c + 1 : c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(s * 2^sh / n) without overflowing the product
    function automatic longint unsigned frac_div(longint unsigned s, longint unsigned n,
                                                 int sh);
        longint unsigned q, r;
        q = s / n;
        r = s % n;
        return (q << sh) + ((r << sh) / n);
    endfunction

    task automatic clear_accumulators();
        for (int c = 0; c < NCH; c++)
        begin
            n_samples[c] = 0; n_over[c] = 0; n_under[c] = 0;
            n_fault[c] = 0; n_range[c] = 0;
            raw_lo[c] = '0; raw_hi[c] = '0;
            raw_acc[c] = 0; sq_acc[c] = 0; temp_acc[c] = 0;
            temp_lo[c] = '0; temp_hi[c] = '0;
        end
    endtask

    task automatic accumulate_sample(int c, logic [RAW_W-1:0] raw,
                                     logic signed [TEMP_W-1:0] temp,
                                     logic [STATUS_W-1:0] st);
        longint unsigned r;
        r = {48'd0, raw};
        if (n_samples[c] >= (64'd1 << CNT_W) - 1) return;
        if (n_samples[c] == 0)
        begin
            raw_lo[c] = raw; raw_hi[c] = raw;
            temp_lo[c] = temp; temp_hi[c] = temp;
        end
        else
        begin
            if (raw < raw_lo[c]) raw_lo[c] = raw;
            if (raw > raw_hi[c]) raw_hi[c] = raw;
            if (temp < temp_lo[c]) temp_lo[c] = temp;
            if (temp > temp_hi[c]) temp_hi[c] = temp;
        end
        n_samples[c]++;
        raw_acc[c] += r;
        sq_acc[c]  += r * r;
        temp_acc[c] += longint'(temp);
        if (raw > over_limit)  n_over[c]  = count_step(n_over[c]);
        if (raw < under_limit) n_under[c] = count_step(n_under[c]);
        if ((st & fault_mask) != 0) n_fault[c] = count_step(n_fault[c]);
        if ((st & range_mask) != 0) n_range[c] = count_step(n_range[c]);
    endtask

    task automatic predict_summary(logic [CH_W-1:0] ch);
        longint unsigned v[13];
        longint unsigned n, mean, msq, msq2, mag;
        bit neg;
        stat_item_t it;
        foreach (v[k]) v[k] = 0;
        if (ch < NCH && n_samples[ch] != 0)
        begin
            n = n_samples[ch];
            mean = frac_div(raw_acc[ch], n, FRAC);
            msq  = frac_div(sq_acc[ch], n, 2 * FRAC);
            msq2 = mean * mean;
            neg  = temp_acc[ch] < 0;
            mag  = neg ? -temp_acc[ch] : temp_acc[ch];
            mag  = frac_div(mag, n, FRAC);
            v[STAT_COUNT]    = n;
            v[STAT_OVER]     = n_over[ch];
            v[STAT_UNDER]    = n_under[ch];
            v[STAT_FAULT]    = n_fault[ch];
            v[STAT_RANGE]    = n_range[ch];
            v[STAT_MEAN]     = mean;
            v[STAT_RMS]      = int_sqrt(msq);
            v[STAT_MIN]      = {48'd0, raw_lo[ch]};
            v[STAT_MAX]      = {48'd0, raw_hi[ch]};
            v[STAT_STDDEV]   = (msq >= msq2) ? int_sqrt(msq - msq2) : 0;
            v[STAT_TEMP_AVG] = neg ? -mag : mag;
            v[STAT_TEMP_MIN] = longint'(temp_lo[ch]);
            v[STAT_TEMP_MAX] = longint'(temp_hi[ch]);
        end
        for (int k = 0; k < NUM_STATS; k++)
        begin
            it.ch = ch;
            it.idx = k[IDX_W-1:0];
            it.value = v[k];
            it.last = (k == NUM_STATS - 1);
            expected_stats.push_back(it);
        end
    endtask

    // ---------------- stimulus helpers ----------------
    // valid stays high after acceptance until the next item, an idle gap or a
    // drain takes over in the same time step
    task automatic send_item(logic [OP_W-1:0] op, int ch, int raw, int temp, int st);
        logic [CH_W-1:0]          ch_b;
        logic [RAW_W-1:0]         raw_b;
        logic signed [TEMP_W-1:0] temp_b;
        logic [STATUS_W-1:0]      st_b;
        ch_b   = CH_W'(ch);
        raw_b  = RAW_W'(raw);
        temp_b = TEMP_W'(temp);
        st_b   = STATUS_W'(st);
        if (idle_sender && $urandom_range(0, 3) == 0)
        begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        samples.valid       <= 1'b1;
        samples.opcode      <= op;
        samples.channel     <= ch_b;
        samples.adc_code    <= raw_b;
        samples.temp_tenths <= temp_b;
        samples.status_bits <= st_b;
        do @(posedge clk); while (!samples.ready);
        // predictor update on acceptance
        if (op == OP_ADD && ch < NCH)
            accumulate_sample(ch, raw_b, temp_b, st_b);
        else if (op == OP_CLEAR)
            clear_accumulators();
        else if (op == OP_READ)
            predict_summary(ch_b);
    endtask

    task automatic wait_drained();
        samples.valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_OVER_LIMIT:  over_limit  = val;
            CFG_UNDER_LIMIT: under_limit = val;
            CFG_FAULT_MASK:  fault_mask  = val[MASK_W-1:0];
            CFG_RANGE_MASK:  range_mask  = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_add(int ch_hi);
        send_item(OP_ADD, $urandom_range(0, ch_hi), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 255));
    endtask

    // ---------------- result checker ----------------
    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && stats.valid && stats.ready)
        begin
            if (expected_stats.size() == 0)
                report_mismatch("unexpected item", 64'(stats.stat_index), 0);
            else
            begin
                stat_item_t want;
                want = expected_stats.pop_front();
                if (stats.stat_channel !== want.ch)
                    report_mismatch("channel", 64'(stats.stat_channel), 64'(want.ch));
                if (stats.stat_index !== want.idx)
                    report_mismatch("index", 64'(stats.stat_index), 64'(want.idx));
                if (stats.stat_value !== want.value)
                    report_mismatch("value", stats.stat_value, want.value);
                if (stats.last !== want.last)
                    report_mismatch("last", 64'(stats.last), 64'(want.last));
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        int hold;
        if (!idle_receiver)
            stats.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            stats.ready <= (stall_left == 1);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(1, 16);
            stall_left <= hold;
            stats.ready <= 1'b0;
        end
        else
            stats.ready <= 1'b1;
    end

    // ---------------- tests ----------------
    task automatic test_empty_and_out_of_range();
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, 255, 65535, -1, 255);
        send_item(OP_ADD, 255, 'h1234, 10, 255);      // ignored
        send_item(OP_ADD, NCH, 'h1234, 10, 255);      // ignored
        send_item(OP_READ, NCH, 0, 0, 0);
        send_item(OP_UNUSED, 1, 'h5555, 5, 0);
        send_item(OP_READ, 1, 0, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_item(OP_ADD, 0, 65535, 32767, 255);
        send_item(OP_ADD, 0, 0, -32768, 0);
        send_item(OP_ADD, 0, 'h8000, -1, 1);
        send_item(OP_ADD, NCH - 1, 1, 0, 2);
        send_item(OP_ADD, NCH - 1, 'hAAAA, -250, 'h55);
        send_item(OP_ADD, 3, 'h7FFF, 1, 'hAA);
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, NCH - 1, 0, 0, 0);
        send_item(OP_READ, 3, 0, 0, 0);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_ADD, 2, 100, -7, 3);
        send_item(OP_READ, 2, 0, 0, 0);
    endtask

    task automatic test_thresholds(logic [15:0] ovr, logic [15:0] und,
                                   logic [7:0] fm, logic [7:0] rm, int n);
        write_register(CFG_OVER_LIMIT, ovr);
        write_register(CFG_UNDER_LIMIT, und);
        write_register(CFG_FAULT_MASK, {8'h00, fm});
        write_register(CFG_RANGE_MASK, {8'h00, rm});
        send_item(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 9) == 0)
                send_item(OP_READ, $urandom_range(0, NCH - 1), 0, 0, 0);
            else
                random_add(NCH - 1);
        for (int c = 0; c < NCH; c += 3)
            send_item(OP_READ, c, 0, 0, 0);
    endtask

    task automatic test_random_mix(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                random_add(NCH - 1);
            else if (sel < 88)
                send_item(OP_READ, $urandom_range(0, NCH - 1), 0, 0, 0);
            else if (sel < 92)
                send_item(OP_READ, $urandom_range(0, 255), 0, 0, 0);
            else if (sel < 96)
                random_add(255);
            else if (sel < 98)
                send_item(OP_CLEAR, $urandom_range(0, 255), 0, 0, 0);
            else
                send_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 65535),
                          0, 0);
        end
    endtask

    task automatic test_pause_until_drained();
        send_item(OP_READ, 4, 0, 0, 0);
        // sender holds off until every outstanding statistic has arrived
        samples.valid <= 1'b0;
        do @(posedge clk); while (expected_stats.size() != 0);
        send_item(OP_ADD, 4, 9, 9, 1);
        send_item(OP_READ, 4, 0, 0, 0);
    endtask

    // ---------------- sequencer ----------------
    initial
    begin
        errors = 0;
        cycles = 0;
        stall_left = 0;
        idle_sender = 1'b1;
        idle_receiver = 1'b1;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        samples.valid = 1'b0;
        samples.opcode = '0;
        samples.channel = '0;
        samples.adc_code = '0;
        samples.temp_tenths = '0;
        samples.status_bits = '0;
        stats.ready = 1'b0;
        over_limit  = RST_OVER_LIMIT;
        under_limit = RST_UNDER_LIMIT;
        fault_mask  = RST_FAULT_MASK;
        range_mask  = RST_RANGE_MASK;
        clear_accumulators();
        @(posedge rst_n);
        @(posedge clk);

        test_empty_and_out_of_range();
        test_field_extremes();
        test_clear();
        test_pause_until_drained();
        test_thresholds(16'h8000, 16'h4000, 8'hF0, 8'h0F, 15);
        test_thresholds(16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 12);
        test_thresholds(16'hFFFF, 16'h0000, 8'h00, 8'h00, 10);
        test_random_mix(30);
        // closing stretch without idling on either side
        idle_sender = 1'b0;
        idle_receiver = 1'b0;
        test_random_mix(15);

        wait_drained();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
